// ===== rtl/integer_array_sorter_top_assert.svh =====
// Assertion macros shared by the sorter checker.
`ifndef INTEGER_ARRAY_SORTER_TOP_ASSERT_SVH
`define INTEGER_ARRAY_SORTER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define IAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define IAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ias_pkg.sv =====
// Shared types and constants of the integer array sorter.
package ias_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // paddr[2] selects the register slot; slot 0 holds the order bit
  localparam logic ADDR_ORDER = 1'b0;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } ias_entry_t;

  typedef enum logic [2:0] {
    ST_FILL  = 3'b001,
    ST_ALIGN = 3'b010,
    ST_DRAIN = 3'b100
  } ias_state_e;

endpackage

// ===== rtl/integer_array_sorter_top.sv =====
// Top level of the integer array sorter: queue, insertion chain and register port.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o, value_i, last_in_i): one signed
//    32-bit element per transaction; last_in_i closes the set. Elements past
//    DEPTH are dropped, but a dropped element marked last still closes the set.
//  - Output channel (out_valid_o/out_ready_i, sorted_value_o, last_out_o):
//    the whole set, one value per transaction, last_out_o on the final one.
//  - APB port: register 0 at byte address 0, bit 0 = ascending order (reset 1).
//    The order in force when the closing element reaches the chain is used.
//  - Throughput: elements enter at one per cycle while the chain is filling;
//    each element that fits is inserted into the chain in the cycle it leaves
//    the two-entry queue, since all DEPTH cells compare against it in parallel.
//  - Drain: in ascending order the closing element passes the queue, the
//    chain cells and the output register before the first result; descending
//    order first adds the align state while the chain shifts the set up to its
//    top cell. Results then leave at one per cycle while the receiver is ready.
//  - While the chain drains, the queue fills and then holds in_ready_o low.
//  - A stalled receiver holds the output register; the chain waits with it.
//  - Reset empties the queue and the chain and sets ascending order.
module integer_array_sorter_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ias_pkg::VALUE_W-1:0]    value_i,
  input  logic                                  last_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ias_pkg::VALUE_W-1:0]    sorted_value_o,
  output logic                                  last_out_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ias_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [ias_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [ias_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  logic                asc_q, asc_d;
  logic                cfg_write;
  logic                entry_valid;
  logic                entry_pop;
  ias_pkg::ias_entry_t entry;

  // Register port: zero wait states, write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    asc_d = asc_q;
    if (cfg_write && (paddr[2] == ias_pkg::ADDR_ORDER)) begin
      asc_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asc_q <= 1'b1;
    end else begin
      asc_q <= asc_d;
    end
  end

  // Unmapped slots read as zero.
  assign prdata = (paddr[2] == ias_pkg::ADDR_ORDER) ?
                  {{(ias_pkg::APB_DATA_W-1){1'b0}}, asc_q} : '0;

  // Front end: take each transaction and queue it with its closing tag.
  ias_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_in_i     (last_in_i),
    .entry_valid_o (entry_valid),
    .entry_o       (entry),
    .entry_pop_i   (entry_pop)
  );

  // Back end: insert into the sorted chain, then drain in the selected order.
  ias_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .asc_i          (asc_q),
    .entry_valid_i  (entry_valid),
    .entry_i        (entry),
    .entry_pop_o    (entry_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_out_o     (last_out_o)
  );

endmodule

// ===== rtl/ias_queue.sv =====
// Front end: accepts input transactions, tags them and queues them for the chain.
module ias_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [ias_pkg::VALUE_W-1:0] value_i,
  input  logic                            last_in_i,
  output logic                            entry_valid_o,
  output ias_pkg::ias_entry_t             entry_o,
  input  logic                            entry_pop_i
);

  ias_pkg::ias_entry_t              mem_q [ias_pkg::QUEUE_DEPTH];
  logic [ias_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ias_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ias_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             push;
  logic                             pop;

  assign in_ready_o    = (count_q != ias_pkg::QCNT_W'(ias_pkg::QUEUE_DEPTH));
  assign entry_valid_o = (count_q != '0);
  assign entry_o       = mem_q[rd_ptr_q];
  assign push          = in_valid_i && in_ready_o;
  assign pop           = entry_pop_i && entry_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{value: value_i, last: last_in_i};
    end
  end

endmodule

// ===== rtl/ias_chain.sv =====
// Back end: insertion chain that keeps the set sorted and drains it in order.
module ias_chain #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               asc_i,
  input  logic                               entry_valid_i,
  input  ias_pkg::ias_entry_t                entry_i,
  output logic                               entry_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ias_pkg::VALUE_W-1:0] sorted_value_o,
  output logic                               last_out_o
);

  // cells hold the set ascending from cell 0; empty cells sit above until ST_ALIGN
  logic signed [ias_pkg::VALUE_W-1:0] cell_q [DEPTH];
  logic signed [ias_pkg::VALUE_W-1:0] cell_d [DEPTH];
  logic [DEPTH-1:0]                   valid_q, valid_d;
  logic [DEPTH-1:0]                   gt;
  ias_pkg::ias_state_e                state_q, state_d;
  logic                               order_q, order_d;
  logic                               out_valid_q, out_valid_d;
  logic signed [ias_pkg::VALUE_W-1:0] out_value_q, out_value_d;
  logic                               out_last_q, out_last_d;
  logic                               pop, insert, out_load, shift_dn, shift_up, drain_last;

  // empty cells count as larger than any value
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = !valid_q[i] || (cell_q[i] > entry_i.value);
    end
  end

  assign pop         = entry_valid_i && (state_q == ias_pkg::ST_FILL);
  assign insert      = pop && !valid_q[DEPTH-1];
  assign out_load    = (state_q == ias_pkg::ST_DRAIN) && (!out_valid_q || out_ready_i);
  assign shift_dn    = out_load && order_q;
  assign shift_up    = ((state_q == ias_pkg::ST_ALIGN) && !valid_q[DEPTH-1]) ||
                       (out_load && !order_q);
  assign drain_last  = order_q ? !valid_q[1] : !valid_q[DEPTH-2];
  assign entry_pop_o = pop;

  always_comb begin
    cell_d  = cell_q;
    valid_d = valid_q;
    if (insert) begin
      cell_d[0]  = gt[0] ? entry_i.value : cell_q[0];
      valid_d[0] = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
        if (gt[i]) begin
          cell_d[i] = gt[i-1] ? cell_q[i-1] : entry_i.value;
        end
        valid_d[i] = valid_q[i] || valid_q[i-1];
      end
    end else if (shift_dn) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        cell_d[i]  = cell_q[i+1];
        valid_d[i] = valid_q[i+1];
      end
      valid_d[DEPTH-1] = 1'b0;
    end else if (shift_up) begin
      for (int i = 1; i < DEPTH; i++) begin
        cell_d[i]  = cell_q[i-1];
        valid_d[i] = valid_q[i-1];
      end
      valid_d[0] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    order_d = order_q;
    case (state_q)
      ias_pkg::ST_FILL: begin
        if (pop && entry_i.last) begin
          order_d = asc_i;
          state_d = asc_i ? ias_pkg::ST_DRAIN : ias_pkg::ST_ALIGN;
        end
      end
      ias_pkg::ST_ALIGN: begin
        if (valid_q[DEPTH-1]) begin
          state_d = ias_pkg::ST_DRAIN;
        end
      end
      ias_pkg::ST_DRAIN: begin
        if (out_load && drain_last) begin
          state_d = ias_pkg::ST_FILL;
        end
      end
      default: state_d = ias_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_value_d = order_q ? cell_q[0] : cell_q[DEPTH-1];
      out_last_d  = drain_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      state_q     <= ias_pkg::ST_FILL;
      order_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      state_q     <= state_d;
      order_q     <= order_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q      <= cell_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_out_o     = out_last_q;

endmodule

// ===== rtl/ias_checker.sv =====
// Port-level checker for the integer array sorter, bound to the top level.
`include "integer_array_sorter_top_assert.svh"

module ias_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [ias_pkg::VALUE_W-1:0] sorted_value_o,
  input logic                               last_out_o,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [ias_pkg::APB_ADDR_W-1:0]     paddr,
  input logic [ias_pkg::APB_DATA_W-1:0]     pwdata,
  input logic [ias_pkg::APB_DATA_W-1:0]     prdata,
  input logic                               pready
);

  // hold a stalled result
  `IAS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(sorted_value_o) && $stable(last_out_o), "output changed while stalled")

  // a write to the order register reads back next cycle
  `IAS_ASSERT_SAME(a_order_readback, (psel && penable && pwrite && pready && (paddr[2] == ias_pkg::ADDR_ORDER)) ##1 (paddr[2] == ias_pkg::ADDR_ORDER), (prdata[0] == $past(pwdata[0])) && (prdata[ias_pkg::APB_DATA_W-1:1] == '0), "order register readback mismatch")

  // zero wait states
  `IAS_ASSERT_SAME(a_pready_high, psel, pready, "pready low")

endmodule

bind integer_array_sorter_top ias_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the integer array sorter: directed, random and stall tests.
module tb_top;

  localparam int unsigned SORT_DEPTH = 64;
  // Cycles to let the chain settle after the last expected result.
  localparam int unsigned SETTLE_CYCLES = SORT_DEPTH + 8;
  localparam int unsigned DRAIN_GUARD = 50000;
  localparam int unsigned RANDOM_ITEMS = 90;
  localparam int unsigned MAX_REPORTS = 10;

  // Register map: slot 0 holds the order bit, slot 1 is unused.
  localparam logic [ias_pkg::APB_ADDR_W-1:0] ORDER_ADDR = {ias_pkg::ADDR_ORDER, 2'b00};
  localparam logic [ias_pkg::APB_ADDR_W-1:0] UNUSED_ADDR = {~ias_pkg::ADDR_ORDER, 2'b00};

  localparam logic signed [ias_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [ias_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // Clock, reset and block inputs, all known from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [ias_pkg::VALUE_W-1:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ias_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [ias_pkg::APB_DATA_W-1:0] pwdata = '0;

  logic in_ready;
  logic out_valid;
  logic signed [ias_pkg::VALUE_W-1:0] sorted_value;
  logic last_out;
  logic [ias_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // Predictor state: the set being collected and the order in force.
  logic signed [ias_pkg::VALUE_W-1:0] set_elems [SORT_DEPTH];
  int unsigned set_fill = 0;
  logic order_ascending = 1'b1;

  // Sorted values still owed by the block, oldest first.
  ias_pkg::ias_entry_t pending_sorted [$];
  ias_pkg::ias_entry_t head_beat;
  int unsigned mismatch_count = 0;

  // Idling controls shared by the sender, the receiver and the tests.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int unsigned hold_off_req = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_phase_left = 0;
  bit rx_phase_ready = 1'b1;

  integer_array_sorter_top #(
    .DEPTH(SORT_DEPTH)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .value_i        (in_value),
    .last_in_i      (in_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sorted_value_o (sorted_value),
    .last_out_o     (last_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  // Count a mismatch; report only the first few in detail.
  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Gap length: mostly none, often short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Element values: mostly full-range, plus clustered values to force
  // duplicates, and the signed extremes.
  function automatic logic signed [ias_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom;
      6, 7: return int'($urandom_range(0, 15)) - 8;
      8: return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
      default: return ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
    endcase
  endfunction

  // Set size: mostly small sets, a few large sets up to the full store.
  function automatic int unsigned rand_set_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 10);
    if (roll < 95) return $urandom_range(11, 30);
    return $urandom_range(50, SORT_DEPTH);
  endfunction

  // Sort the collected set with the current order and queue the results.
  task automatic close_set();
    int unsigned i;
    int unsigned pos;
    logic signed [ias_pkg::VALUE_W-1:0] held;
    ias_pkg::ias_entry_t beat;
    for (i = 1; i < set_fill; i++) begin
      held = set_elems[i];
      pos = i;
      while (pos > 0 && (order_ascending ? (set_elems[pos-1] > held)
                                         : (set_elems[pos-1] < held))) begin
        set_elems[pos] = set_elems[pos-1];
        pos--;
      end
      set_elems[pos] = held;
    end
    for (i = 0; i < set_fill; i++) begin
      beat.value = set_elems[i];
      beat.last = (i + 1 == set_fill);
      pending_sorted.push_back(beat);
    end
    set_fill = 0;
  endtask

  // Predict on every accepted input transaction. Elements past the store
  // depth are dropped, but a dropped closing element still closes the set.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (set_fill < SORT_DEPTH) begin
        set_elems[set_fill] = in_value;
        set_fill++;
      end
      if (in_last) close_set();
    end
  end

  // Compare each accepted output transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        flag_mismatch("unexpected result", '0, sorted_value);
      end else begin
        head_beat = pending_sorted.pop_front();
        if (sorted_value !== head_beat.value)
          flag_mismatch("sorted_value", head_beat.value, sorted_value);
        if (last_out !== head_beat.last)
          flag_mismatch("last_out", head_beat.last, last_out);
      end
    end
  end

  // Receiver: honor a requested hold-off first, counting it down here;
  // otherwise alternate ready and stall phases of random length.
  always @(negedge clk) begin
    if (hold_off_req > 0) begin
      rx_hold = hold_off_req;
      hold_off_req = 0;
    end
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (!rx_idle_on) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        if ($urandom_range(0, 2) != 0) begin
          rx_phase_ready = 1'b1;
          rx_phase_left = $urandom_range(1, 10);
        end else begin
          rx_phase_ready = 1'b0;
          rx_phase_left = gap_len() + 1;
        end
      end
      out_ready <= rx_phase_ready;
      rx_phase_left--;
    end
  end

  // Offer one element; called at a falling edge, returns at a falling edge
  // with valid still high so back-to-back transactions need no gap.
  task automatic send_element(input logic signed [ias_pkg::VALUE_W-1:0] value,
                              input logic last);
    int unsigned gap;
    gap = tx_idle_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_set(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_element(rand_value(), k + 1 == count);
  endtask

  // Drop valid, wait for every owed result, then let the chain settle.
  task automatic settle();
    int unsigned guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_sorted.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write: setup cycle, then access until pready.
  task automatic apb_write(input logic [ias_pkg::APB_ADDR_W-1:0] addr,
                           input logic [ias_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Only the low bit of the order register is kept.
    if (addr == ORDER_ADDR) order_ascending = data[0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read the order register back and check its bit.
  task automatic check_order_reg();
    logic [ias_pkg::APB_DATA_W-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ORDER_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== order_ascending) flag_mismatch("order register", order_ascending, rd);
  endtask

  // Write the order bit with random upper bits, then read it back.
  task automatic set_order(input logic ascending);
    apb_write(ORDER_ADDR, {31'($urandom_range(0, 32'h7fff_ffff)), ascending});
    check_order_reg();
  endtask

  // Ascending extremes, a single-element set, duplicates; also poke the
  // unused register slot and confirm the order bit survives.
  task automatic test_directed_ascending();
    check_order_reg();
    set_order(1'b1);
    apb_write(UNUSED_ADDR, 32'hffff_fffe);
    check_order_reg();
    send_element(32'sd0, 1'b1);
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'sd0, 1'b0);
    send_element(32'sd1, 1'b1);
    send_element(32'sd5, 1'b0);
    send_element(32'sd5, 1'b0);
    send_element(-32'sd5, 1'b0);
    send_element(32'sd5, 1'b1);
    settle();
  endtask

  // Descending with alternating bit patterns and extremes.
  task automatic test_directed_descending();
    set_order(1'b0);
    send_element(VAL_MIN, 1'b0);
    send_element(32'sh5555_5555, 1'b0);
    send_element(32'shAAAA_AAAA, 1'b0);
    send_element(VAL_MAX, 1'b0);
    send_element(-32'sd1, 1'b1);
    send_element(VAL_MIN, 1'b1);
    send_element(32'sd7, 1'b0);
    send_element(32'sd7, 1'b1);
    settle();
  endtask

  // Change the order while a set is half collected; the order in force
  // when the closing element arrives must win.
  task automatic test_order_change_mid_set();
    set_order(1'b1);
    send_element(rand_value(), 1'b0);
    send_element(rand_value(), 1'b0);
    send_element(rand_value(), 1'b0);
    settle();
    set_order(1'b0);
    send_element(rand_value(), 1'b0);
    send_element(rand_value(), 1'b1);
    settle();
  endtask

  // Overfill the store: the extra elements are dropped, the dropped
  // closing element still closes the full set.
  task automatic test_store_overflow();
    set_order(1'b1);
    tx_idle_on = 1'b0;
    send_random_set(SORT_DEPTH + 3);
    settle();
    tx_idle_on = 1'b1;
  endtask

  // Random sets in phases, each phase with its own order and idling mix.
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned size;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_order($urandom_range(0, 1));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      phase_sent = 0;
      while (phase_sent < 22) begin
        size = rand_set_size();
        send_random_set(size);
        phase_sent += size;
      end
      sent += phase_sent;
      settle();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering back-to-back sets, so the block fills and stalls its input.
  task automatic test_output_stall();
    int unsigned s;
    set_order(1'b0);
    tx_idle_on = 1'b0;
    @(posedge clk);
    hold_off_req = 300;
    @(negedge clk);
    for (s = 0; s < 5; s++) send_random_set(6);
    settle();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ascending();
    test_directed_descending();
    test_order_change_mid_set();
    test_store_overflow();
    test_random_sets();
    test_output_stall();

    settle();
    if (pending_sorted.size() != 0)
      flag_mismatch("results left over", pending_sorted.size(), '0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== integer_array_sorter_top.f =====
+incdir+rtl
rtl/ias_pkg.sv
rtl/ias_queue.sv
rtl/ias_chain.sv
rtl/integer_array_sorter_top.sv
rtl/ias_checker.sv
tb/sv/tb_top.sv
